// File: rtl/core/swlr_pkg.sv
// Shared types, codes and the operation sequence of the sliding-window line fit.
package swlr_pkg;

  localparam int CfgW  = 7;
  localparam int OutW  = 48;
  localparam int PcW   = 5;
  localparam logic [CfgW-1:0] WindowLengthReset = 7'd64;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_ADD,
    ALU_MUL,
    ALU_DABSN,
    ALU_DABSD,
    ALU_DIV,
    ALU_DNEG
  } alu_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } seq_state_e;

  localparam int SrcCount = 18;

  typedef enum logic [4:0] {
    SRC_N, SRC_SX, SRC_SY, SRC_SXX, SRC_SXY, SRC_X, SRC_Y, SRC_OX, SRC_OY, SRC_LX,
    SRC_T0, SRC_T1, SRC_DET, SRC_NS, SRC_NT, SRC_NS_SH16, SRC_NT_SH8, SRC_T0_SH8
  } src_e;

  typedef enum logic [3:0] {
    DST_SX, DST_SY, DST_SXX, DST_SXY, DST_T0, DST_T1, DST_DET, DST_NS, DST_NT,
    DST_SLOPE, DST_ICPT, DST_FITL, DST_FCST, DST_REVX
  } dst_e;

  typedef struct packed {
    alu_op_e op;
    src_e    a;
    src_e    b;
    dst_e    dst;
  } uop_t;

  localparam logic [PcW-1:0] PC_EVICT = 5'd0;
  localparam logic [PcW-1:0] PC_ADD   = 5'd6;
  localparam logic [PcW-1:0] PC_FIT   = 5'd12;
  localparam logic [PcW-1:0] PC_NS    = 5'd15;
  localparam logic [PcW-1:0] PC_REV   = 5'd29;
  localparam logic [PcW-1:0] PC_LAST  = 5'd31;

  function automatic uop_t uop_at(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = '{OP_MUL, SRC_OX, SRC_OX, DST_T0};
      5'd1:    u = '{OP_SUB, SRC_SXX, SRC_T0, DST_SXX};
      5'd2:    u = '{OP_MUL, SRC_OX, SRC_OY, DST_T0};
      5'd3:    u = '{OP_SUB, SRC_SXY, SRC_T0, DST_SXY};
      5'd4:    u = '{OP_SUB, SRC_SX, SRC_OX, DST_SX};
      5'd5:    u = '{OP_SUB, SRC_SY, SRC_OY, DST_SY};
      5'd6:    u = '{OP_MUL, SRC_X, SRC_X, DST_T0};
      5'd7:    u = '{OP_ADD, SRC_SXX, SRC_T0, DST_SXX};
      5'd8:    u = '{OP_MUL, SRC_X, SRC_Y, DST_T0};
      5'd9:    u = '{OP_ADD, SRC_SXY, SRC_T0, DST_SXY};
      5'd10:   u = '{OP_ADD, SRC_SX, SRC_X, DST_SX};
      5'd11:   u = '{OP_ADD, SRC_SY, SRC_Y, DST_SY};
      5'd12:   u = '{OP_MUL, SRC_SXX, SRC_N, DST_T0};
      5'd13:   u = '{OP_MUL, SRC_SX, SRC_SX, DST_T1};
      5'd14:   u = '{OP_SUB, SRC_T0, SRC_T1, DST_DET};
      5'd15:   u = '{OP_MUL, SRC_SXY, SRC_N, DST_T0};
      5'd16:   u = '{OP_MUL, SRC_SX, SRC_SY, DST_T1};
      5'd17:   u = '{OP_SUB, SRC_T0, SRC_T1, DST_NS};
      5'd18:   u = '{OP_MUL, SRC_SXX, SRC_SY, DST_T0};
      5'd19:   u = '{OP_MUL, SRC_SXY, SRC_SX, DST_T1};
      5'd20:   u = '{OP_SUB, SRC_T0, SRC_T1, DST_NT};
      5'd21:   u = '{OP_DIV, SRC_NS_SH16, SRC_DET, DST_SLOPE};
      5'd22:   u = '{OP_DIV, SRC_NT_SH8, SRC_DET, DST_ICPT};
      5'd23:   u = '{OP_MUL, SRC_NS, SRC_LX, DST_T0};
      5'd24:   u = '{OP_ADD, SRC_T0, SRC_NT, DST_T0};
      5'd25:   u = '{OP_DIV, SRC_T0_SH8, SRC_DET, DST_FITL};
      5'd26:   u = '{OP_MUL, SRC_NS, SRC_X, DST_T0};
      5'd27:   u = '{OP_ADD, SRC_T0, SRC_NT, DST_T0};
      5'd28:   u = '{OP_DIV, SRC_T0_SH8, SRC_DET, DST_FCST};
      5'd29:   u = '{OP_MUL, SRC_DET, SRC_Y, DST_T0};
      5'd30:   u = '{OP_SUB, SRC_T0, SRC_NT, DST_T0};
      5'd31:   u = '{OP_DIV, SRC_T0_SH8, SRC_NS, DST_REVX};
      default: u = '{OP_ADD, SRC_T0, SRC_T0, DST_T0};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/core/swlr_ram.sv
// Generic simple dual-port RAM with registered read.
module swlr_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/swlr_alu.sv
// Shared arithmetic unit: one adder for add, shift-add multiply and restoring divide.
module swlr_alu #(
  parameter int DataW = 94,
  parameter int MulBW = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swlr_pkg::alu_req_t  req_i,
  input  logic [DataW-1:0]    a_i,
  input  logic [DataW-1:0]    b_i,
  output logic                done_o,
  output logic [DataW-1:0]    result_o
);

  localparam int CntW = $clog2(DataW);

  swlr_pkg::alu_state_e state_q, state_d;
  logic             done_q;
  logic [DataW-1:0] acc_q, opa_q, opb_q;
  logic [MulBW-1:0] mb_q;
  logic [CntW-1:0]  cnt_q;
  logic             sub_q, neg_q;
  logic [DataW-1:0] add_x, add_y, add_s, r2;
  logic             add_inv;

  assign r2 = {acc_q[DataW-2:0], opb_q[DataW-1]};

  always_comb begin
    state_d = state_q;
    add_x   = '0;
    add_y   = opa_q;
    add_inv = 1'b0;
    case (state_q)
      swlr_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            swlr_pkg::OP_MUL: state_d = swlr_pkg::ALU_MUL;
            swlr_pkg::OP_DIV: state_d = swlr_pkg::ALU_DABSN;
            default:          state_d = swlr_pkg::ALU_ADD;
          endcase
        end
      end
      swlr_pkg::ALU_ADD: begin
        add_x   = acc_q;
        add_inv = sub_q;
        state_d = swlr_pkg::ALU_IDLE;
      end
      swlr_pkg::ALU_MUL: begin
        add_x   = {acc_q[DataW-2:0], 1'b0};
        add_inv = (cnt_q == CntW'(MulBW - 1));
        if (cnt_q == '0) begin
          state_d = swlr_pkg::ALU_IDLE;
        end
      end
      swlr_pkg::ALU_DABSN: begin
        add_y   = opb_q;
        add_inv = 1'b1;
        state_d = swlr_pkg::ALU_DABSD;
      end
      swlr_pkg::ALU_DABSD: begin
        add_inv = 1'b1;
        state_d = swlr_pkg::ALU_DIV;
      end
      swlr_pkg::ALU_DIV: begin
        add_x   = r2;
        add_inv = 1'b1;
        if (cnt_q == '0) begin
          state_d = swlr_pkg::ALU_DNEG;
        end
      end
      swlr_pkg::ALU_DNEG: begin
        add_y   = opb_q;
        add_inv = 1'b1;
        state_d = swlr_pkg::ALU_IDLE;
      end
      default: state_d = swlr_pkg::ALU_IDLE;
    endcase
    add_s = add_x + (add_inv ? ~add_y : add_y) + DataW'(add_inv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swlr_pkg::ALU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == swlr_pkg::ALU_ADD) || (state_q == swlr_pkg::ALU_DNEG) ||
                 ((state_q == swlr_pkg::ALU_MUL) && (cnt_q == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      swlr_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          sub_q <= (req_i.op == swlr_pkg::OP_SUB);
          case (req_i.op)
            swlr_pkg::OP_MUL: begin
              acc_q <= '0;
              opa_q <= a_i;
              mb_q  <= b_i[MulBW-1:0];
              cnt_q <= CntW'(MulBW - 1);
            end
            swlr_pkg::OP_DIV: begin
              opb_q <= a_i;
              opa_q <= b_i;
              neg_q <= a_i[DataW-1] ^ b_i[DataW-1];
            end
            default: begin
              acc_q <= a_i;
              opa_q <= b_i;
            end
          endcase
        end
      end
      swlr_pkg::ALU_ADD: acc_q <= add_s;
      swlr_pkg::ALU_MUL: begin
        acc_q <= mb_q[MulBW-1] ? add_s : add_x;
        mb_q  <= {mb_q[MulBW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      swlr_pkg::ALU_DABSN: begin
        if (opb_q[DataW-1]) begin
          opb_q <= add_s;
        end
      end
      swlr_pkg::ALU_DABSD: begin
        if (opa_q[DataW-1]) begin
          opa_q <= add_s;
        end
        acc_q <= '0;
        cnt_q <= CntW'(DataW - 1);
      end
      swlr_pkg::ALU_DIV: begin
        acc_q <= add_s[DataW-1] ? r2 : add_s;
        opb_q <= {opb_q[DataW-2:0], ~add_s[DataW-1]};
        cnt_q <= cnt_q - 1'b1;
      end
      swlr_pkg::ALU_DNEG: acc_q <= neg_q ? add_s : opb_q;
      default: acc_q <= acc_q;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

// File: rtl/core/sliding_window_linear_regression.sv
// Top level of the sliding-window least-squares line fit.
// Each beat applies its command (add a pair, query, or clear) and returns one result beat
// with slope at 16 fraction bits, intercept, line values and reverse x at 8, and flags.
// A short sequencer runs up to 32 steps on one shared adder: each multiply retires one
// multiplier bit per cycle over SAMPLE_BITS plus count width bits, while each of the five
// divides retires one quotient bit per cycle over the internal width, 94 bits by default.
// A clear or an invalid fit ends early. The input is not ready while an item is in work;
// a finished result waits in the output register while the next beat is taken.
module sliding_window_linear_regression #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic signed [SAMPLE_BITS-1:0]     x_value_i,
  input  logic signed [SAMPLE_BITS-1:0]     y_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [swlr_pkg::OutW-1:0]  slope_o,
  output logic signed [swlr_pkg::OutW-1:0]  intercept_o,
  output logic signed [swlr_pkg::OutW-1:0]  fit_at_last_x_o,
  output logic signed [swlr_pkg::OutW-1:0]  forecast_y_o,
  output logic signed [swlr_pkg::OutW-1:0]  reverse_x_o,
  output logic                              reverse_undefined_o,
  output logic                              fit_valid_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] sample_count_o,
  input  logic                              cfg_we_i,
  input  logic [swlr_pkg::CfgW-1:0]         cfg_wdata_i
);

  localparam int CountW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SlotW     = $clog2(WINDOW_DEPTH);
  localparam int SumW      = SAMPLE_BITS + CountW;
  localparam int Sum2W     = 2 * SAMPLE_BITS + CountW;
  localparam int MulBW     = SumW;
  localparam int DataBound = 3 * SAMPLE_BITS + 2 * CountW + 8;
  localparam int OutW      = swlr_pkg::OutW;
  localparam int DataW     = (DataBound > OutW) ? DataBound : OutW + 1;

  localparam logic [OutW-1:0] SatMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] SatMin = {1'b1, {(OutW-1){1'b0}}};

  function automatic logic [OutW-1:0] sat_out(logic [DataW-1:0] v);
    logic [DataW-OutW:0] upper;
    upper = v[DataW-1:OutW-1];
    if ((&upper) || !(|upper)) begin
      return v[OutW-1:0];
    end
    return v[DataW-1] ? SatMin : SatMax;
  endfunction

  swlr_pkg::seq_state_e state_q, state_d;
  logic [swlr_pkg::PcW-1:0]  pc_q;
  logic [swlr_pkg::CfgW-1:0] wl_q;
  logic [CountW-1:0]         count_q;
  logic [SlotW-1:0]          wslot_q, slot_q;
  logic signed [SumW-1:0]    sx_q, sy_q;
  logic signed [Sum2W-1:0]   sxx_q, sxy_q;
  logic signed [SAMPLE_BITS-1:0] lx_q, x_q, y_q, ox_q, oy_q;
  logic [DataW-1:0]          t0_q, t1_q, det_q, ns_q, nt_q;
  logic [OutW-1:0]           r_slope_q, r_icpt_q, r_fitl_q, r_fcst_q, r_revx_q;
  logic                      r_undef_q, r_valid_q;
  logic [OutW-1:0]           o_slope_q, o_icpt_q, o_fitl_q, o_fcst_q, o_revx_q;
  logic                      o_undef_q, o_valid_fit_q, out_valid_q;
  logic [CountW-1:0]         o_count_q;

  logic                      in_acc, out_load, alu_done;
  logic [31:0]               wl_ext;
  logic [CountW-1:0]         len, slot_inc;
  logic [SlotW-1:0]          slot_sel, slot_next;
  logic                      evict;
  swlr_pkg::uop_t            uop;
  swlr_pkg::alu_req_t        alu_req;
  logic [DataW-1:0]          src_v [swlr_pkg::SrcCount];
  logic [DataW-1:0]          alu_res;
  logic [2*SAMPLE_BITS-1:0]  ram_rdata;

  assign in_ready_o = (state_q == swlr_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == swlr_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    wl_ext = 32'(wl_q);
    if (wl_ext == 32'd0) begin
      len = CountW'(1);
    end else if (wl_ext > 32'(WINDOW_DEPTH)) begin
      len = CountW'(WINDOW_DEPTH);
    end else begin
      len = CountW'(wl_ext);
    end
    slot_sel  = (CountW'(wslot_q) < len) ? wslot_q : '0;
    slot_inc  = CountW'(slot_sel) + 1'b1;
    slot_next = (slot_inc == len) ? '0 : SlotW'(slot_inc);
    evict     = (count_q >= len);
  end

  assign uop = swlr_pkg::uop_at(pc_q);

  assign src_v[swlr_pkg::SRC_N]       = DataW'(count_q);
  assign src_v[swlr_pkg::SRC_SX]      = DataW'(sx_q);
  assign src_v[swlr_pkg::SRC_SY]      = DataW'(sy_q);
  assign src_v[swlr_pkg::SRC_SXX]     = DataW'(sxx_q);
  assign src_v[swlr_pkg::SRC_SXY]     = DataW'(sxy_q);
  assign src_v[swlr_pkg::SRC_X]       = DataW'(x_q);
  assign src_v[swlr_pkg::SRC_Y]       = DataW'(y_q);
  assign src_v[swlr_pkg::SRC_OX]      = DataW'(ox_q);
  assign src_v[swlr_pkg::SRC_OY]      = DataW'(oy_q);
  assign src_v[swlr_pkg::SRC_LX]      = DataW'(lx_q);
  assign src_v[swlr_pkg::SRC_T0]      = t0_q;
  assign src_v[swlr_pkg::SRC_T1]      = t1_q;
  assign src_v[swlr_pkg::SRC_DET]     = det_q;
  assign src_v[swlr_pkg::SRC_NS]      = ns_q;
  assign src_v[swlr_pkg::SRC_NT]      = nt_q;
  assign src_v[swlr_pkg::SRC_NS_SH16] = {ns_q[DataW-17:0], 16'd0};
  assign src_v[swlr_pkg::SRC_NT_SH8]  = {nt_q[DataW-9:0], 8'd0};
  assign src_v[swlr_pkg::SRC_T0_SH8]  = {t0_q[DataW-9:0], 8'd0};

  always_comb begin
    state_d       = state_q;
    alu_req.start = 1'b0;
    alu_req.op    = uop.op;
    case (state_q)
      swlr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (command_i == swlr_pkg::CMD_ADD) ? swlr_pkg::ST_LOAD : swlr_pkg::ST_ISSUE;
        end
      end
      swlr_pkg::ST_LOAD: state_d = swlr_pkg::ST_ISSUE;
      swlr_pkg::ST_ISSUE: begin
        if ((pc_q == swlr_pkg::PC_NS) && (det_q == '0)) begin
          state_d = swlr_pkg::ST_DONE;
        end else if ((pc_q == swlr_pkg::PC_REV) && (ns_q == '0)) begin
          state_d = swlr_pkg::ST_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = swlr_pkg::ST_WAIT;
        end
      end
      swlr_pkg::ST_WAIT: begin
        if (alu_done) begin
          state_d = (pc_q == swlr_pkg::PC_LAST) ? swlr_pkg::ST_DONE : swlr_pkg::ST_ISSUE;
        end
      end
      swlr_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = swlr_pkg::ST_IDLE;
        end
      end
      default: state_d = swlr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swlr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      wl_q        <= swlr_pkg::WindowLengthReset;
      count_q     <= '0;
      wslot_q     <= '0;
      lx_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      sxy_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wl_q    <= cfg_wdata_i;
        count_q <= '0;
        wslot_q <= '0;
        lx_q    <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        sxx_q   <= '0;
        sxy_q   <= '0;
      end else if (in_acc) begin
        case (command_i)
          swlr_pkg::CMD_ADD: begin
            pc_q    <= evict ? swlr_pkg::PC_EVICT : swlr_pkg::PC_ADD;
            count_q <= evict ? count_q : count_q + 1'b1;
            wslot_q <= slot_next;
            lx_q    <= x_value_i;
          end
          swlr_pkg::CMD_CLEAR: begin
            pc_q    <= swlr_pkg::PC_FIT;
            count_q <= '0;
            wslot_q <= '0;
            lx_q    <= '0;
            sx_q    <= '0;
            sy_q    <= '0;
            sxx_q   <= '0;
            sxy_q   <= '0;
          end
          default: pc_q <= swlr_pkg::PC_FIT;
        endcase
      end else if ((state_q == swlr_pkg::ST_WAIT) && alu_done) begin
        pc_q <= pc_q + 1'b1;
        case (uop.dst)
          swlr_pkg::DST_SX:  sx_q  <= SumW'(alu_res);
          swlr_pkg::DST_SY:  sy_q  <= SumW'(alu_res);
          swlr_pkg::DST_SXX: sxx_q <= Sum2W'(alu_res);
          swlr_pkg::DST_SXY: sxy_q <= Sum2W'(alu_res);
          default:           sx_q  <= sx_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q       <= x_value_i;
      y_q       <= y_value_i;
      slot_q    <= slot_sel;
      r_slope_q <= '0;
      r_icpt_q  <= '0;
      r_fitl_q  <= '0;
      r_fcst_q  <= '0;
      r_revx_q  <= '0;
      r_undef_q <= 1'b0;
      r_valid_q <= 1'b1;
    end
    if (state_q == swlr_pkg::ST_LOAD) begin
      ox_q <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      oy_q <= ram_rdata[SAMPLE_BITS-1:0];
    end
    if (state_q == swlr_pkg::ST_ISSUE) begin
      if ((pc_q == swlr_pkg::PC_NS) && (det_q == '0)) begin
        r_valid_q <= 1'b0;
      end else if ((pc_q == swlr_pkg::PC_REV) && (ns_q == '0)) begin
        r_revx_q  <= SatMax;
        r_undef_q <= 1'b1;
      end
    end
    if ((state_q == swlr_pkg::ST_WAIT) && alu_done) begin
      case (uop.dst)
        swlr_pkg::DST_T0:    t0_q      <= alu_res;
        swlr_pkg::DST_T1:    t1_q      <= alu_res;
        swlr_pkg::DST_DET:   det_q     <= alu_res;
        swlr_pkg::DST_NS:    ns_q      <= alu_res;
        swlr_pkg::DST_NT:    nt_q      <= alu_res;
        swlr_pkg::DST_SLOPE: r_slope_q <= sat_out(alu_res);
        swlr_pkg::DST_ICPT:  r_icpt_q  <= sat_out(alu_res);
        swlr_pkg::DST_FITL:  r_fitl_q  <= sat_out(alu_res);
        swlr_pkg::DST_FCST:  r_fcst_q  <= sat_out(alu_res);
        swlr_pkg::DST_REVX:  r_revx_q  <= sat_out(alu_res);
        default:             t0_q      <= t0_q;
      endcase
    end
    if (out_load) begin
      o_slope_q     <= r_slope_q;
      o_icpt_q      <= r_icpt_q;
      o_fitl_q      <= r_fitl_q;
      o_fcst_q      <= r_fcst_q;
      o_revx_q      <= r_revx_q;
      o_undef_q     <= r_undef_q;
      o_valid_fit_q <= r_valid_q;
      o_count_q     <= count_q;
    end
  end

  swlr_alu #(
    .DataW (DataW),
    .MulBW (MulBW)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (src_v[uop.a]),
    .b_i      (src_v[uop.b]),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  swlr_ram #(
    .Width (2 * SAMPLE_BITS),
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == swlr_pkg::ST_LOAD),
    .waddr_i (slot_q),
    .wdata_i ({x_q, y_q}),
    .raddr_i (slot_sel),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign slope_o             = o_slope_q;
  assign intercept_o         = o_icpt_q;
  assign fit_at_last_x_o     = o_fitl_q;
  assign forecast_y_o        = o_fcst_q;
  assign reverse_x_o         = o_revx_q;
  assign reverse_undefined_o = o_undef_q;
  assign fit_valid_o         = o_valid_fit_q;
  assign sample_count_o      = o_count_q;

endmodule
